// File: src/khtt_pkg.sv
// shared types and constants of the key hold and tap tracker
`default_nettype none

package khtt_pkg;

  localparam int unsigned CODE_W  = 31;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned ENTRY_W = CODE_W + TIME_W;

  localparam logic [TIME_W-1:0] TAP_LIMIT_RST = 32'd200;

  typedef enum logic [ACT_W-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_HELD    = 2'd2,
    ACT_TAP     = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_TSCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              push;
    logic              clr;
    logic [CODE_W-1:0] code;
  } tap_cmd_t;

endpackage

`default_nettype wire

// File: src/khtt_ram.sv
// generic single write port ram with registered read
`default_nettype none

module khtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/khtt_cmp_unit.sv
// shared compare unit: code match and wrapping duration against a threshold
`default_nettype none

module khtt_cmp_unit (
  input  wire logic [khtt_pkg::CODE_W-1:0] code_a_i,
  input  wire logic [khtt_pkg::CODE_W-1:0] code_b_i,
  input  wire logic [khtt_pkg::TIME_W-1:0] now_i,
  input  wire logic [khtt_pkg::TIME_W-1:0] since_i,
  input  wire logic [khtt_pkg::TIME_W-1:0] thr_i,
  input  wire logic                        gt_mode_i,
  output logic                             eq_o,
  output logic                             time_ok_o
);
  import khtt_pkg::*;

  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] op_a;
  logic [TIME_W-1:0] op_b;

  // gt mode: thr < dur, else dur < thr
  always_comb begin
    dur       = now_i - since_i;
    op_a      = gt_mode_i ? thr_i : dur;
    op_b      = gt_mode_i ? dur : thr_i;
    time_ok_o = op_a < op_b;
    eq_o      = code_a_i == code_b_i;
  end

endmodule

`default_nettype wire

// File: src/khtt_tap_hist.sv
// tap history shift register with valid bits
`default_nettype none

module khtt_tap_hist #(
  parameter int unsigned TAP_DEPTH = 5
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire khtt_pkg::tap_cmd_t                             cmd_i,
  input  wire logic [(TAP_DEPTH > 1 ? $clog2(TAP_DEPTH) : 1)-1:0] idx_i,
  output logic      [khtt_pkg::CODE_W-1:0]                    code_o,
  output logic                                                valid_o
);
  import khtt_pkg::*;

  logic [CODE_W-1:0]    code_q [TAP_DEPTH];
  logic [TAP_DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      for (int i = TAP_DEPTH - 1; i > 0; i--) begin
        code_q[i] <= code_q[i-1];
      end
      code_q[0] <= cmd_i.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.push) begin
      for (int i = TAP_DEPTH - 1; i > 0; i--) begin
        valid_q[i] <= valid_q[i-1];
      end
      valid_q[0] <= 1'b1;
    end else if (cmd_i.clr) begin
      valid_q[idx_i] <= 1'b0;
    end
  end

  assign code_o  = code_q[idx_i];
  assign valid_o = valid_q[idx_i];

endmodule

`default_nettype wire

// File: src/key_hold_and_tap_tracker_top.sv
// top level of the key hold and tap tracker: sequencer, slot table and tap history
// press, release and held queries scan every slot before the result; a tap query
// scans the tap history, stopping at the first matching tap
// throughput: one word at a time, set by the slot scan through one ram read port
// the result register lets the next word enter while a result waits
// reset clears slot and tap valid bits and control state; the tap limit returns to 200
`default_nettype none

module key_hold_and_tap_tracker_top #(
  parameter int unsigned KEY_SLOTS = 20,
  parameter int unsigned TAP_DEPTH = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [khtt_pkg::ACT_W-1:0]    action_i,
  input  wire logic [khtt_pkg::CODE_W-1:0]   key_code_i,
  input  wire logic [khtt_pkg::TIME_W-1:0]   now_i,
  input  wire logic [khtt_pkg::TIME_W-1:0]   hold_time_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               answer_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [khtt_pkg::TIME_W-1:0]   cfg_data_i
);
  import khtt_pkg::*;

  localparam int unsigned IW   = KEY_SLOTS > 1 ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned TIW  = TAP_DEPTH > 1 ? $clog2(TAP_DEPTH) : 1;
  localparam int unsigned MAXD = KEY_SLOTS > TAP_DEPTH ? KEY_SLOTS : TAP_DEPTH;
  localparam int unsigned CW   = $clog2(MAXD + 1);

  state_e state_q, state_d;

  act_e              act_q;
  logic [CODE_W-1:0] code_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] hold_q;
  logic [TIME_W-1:0] tap_limit_q;

  logic [CW-1:0]        cnt_q;
  logic                 rd_vld_q;
  logic [IW-1:0]        rd_idx_q;
  logic                 found_q;
  logic [IW-1:0]        found_idx_q;
  logic                 tok_q;
  logic                 free_q;
  logic [IW-1:0]        free_idx_q;
  logic [KEY_SLOTS-1:0] valid_q;
  logic                 ans_q;
  logic                 out_valid_q;
  logic                 answer_q;

  logic                 in_acc;
  logic                 scan_more;
  logic                 tscan_more;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic                 ram_we;
  logic [CODE_W-1:0]    tap_code;
  logic                 tap_vld;
  logic [CODE_W-1:0]    cmp_code_b;
  logic                 cmp_eq;
  logic                 cmp_time_ok;
  logic                 slot_hit;
  logic                 slot_free;
  logic                 tap_hit;
  logic                 press_ok;
  tap_cmd_t             tap_cmd;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;

  assign scan_more  = cnt_q < CW'(KEY_SLOTS);
  assign tscan_more = cnt_q < CW'(TAP_DEPTH);

  assign cmp_code_b = (state_q == ST_TSCAN) ? tap_code : ram_rdata[ENTRY_W-1:TIME_W];

  khtt_cmp_unit u_cmp (
    .code_a_i  (code_q),
    .code_b_i  (cmp_code_b),
    .now_i     (now_q),
    .since_i   (ram_rdata[TIME_W-1:0]),
    .thr_i     ((act_q == ACT_HELD) ? hold_q : tap_limit_q),
    .gt_mode_i (act_q == ACT_HELD),
    .eq_o      (cmp_eq),
    .time_ok_o (cmp_time_ok)
  );

  assign slot_hit  = rd_vld_q & valid_q[rd_idx_q] & cmp_eq;
  assign slot_free = rd_vld_q & ~valid_q[rd_idx_q];
  assign tap_hit   = (state_q == ST_TSCAN) & tscan_more & tap_vld & cmp_eq;
  assign press_ok  = (state_q == ST_APPLY) & (act_q == ACT_PRESS) & ~found_q & free_q;
  assign ram_we    = press_ok;

  khtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEY_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i ({code_q, now_q}),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    tap_cmd.push = (state_q == ST_APPLY) & (act_q == ACT_RELEASE) & found_q & tok_q;
    tap_cmd.clr  = tap_hit;
    tap_cmd.code = code_q;
  end

  khtt_tap_hist #(
    .TAP_DEPTH (TAP_DEPTH)
  ) u_tap_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (tap_cmd),
    .idx_i   (cnt_q[TIW-1:0]),
    .code_o  (tap_code),
    .valid_o (tap_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (act_e'(action_i) == ACT_TAP) ? ST_TSCAN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_more && rd_vld_q) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d = ST_DONE;
      end
      ST_TSCAN: begin
        if (!tscan_more || tap_hit) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // item fields, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= act_e'(action_i);
      code_q <= key_code_i;
      now_q  <= now_i;
      hold_q <= hold_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_limit_q <= TAP_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tap_limit_q <= cfg_data_i;
    end
  end

  // scan counter and read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN) & scan_more;
      rd_idx_q <= cnt_q[IW-1:0];
      if (in_acc) begin
        cnt_q <= '0;
      end else if (state_q == ST_SCAN && scan_more) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (state_q == ST_TSCAN && tscan_more && !tap_hit) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // scan results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      found_idx_q <= '0;
      tok_q       <= 1'b0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
    end else if (in_acc) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (slot_hit) begin
        found_q     <= 1'b1;
        found_idx_q <= rd_idx_q;
        tok_q       <= cmp_time_ok;
      end
      if (slot_free && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (press_ok) begin
      valid_q[free_idx_q] <= 1'b1;
    end else if (state_q == ST_APPLY && act_q == ACT_RELEASE && found_q) begin
      valid_q[found_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ans_q <= 1'b0;
    end else if (in_acc) begin
      ans_q <= 1'b0;
    end else if (state_q == ST_APPLY) begin
      ans_q <= (act_q == ACT_HELD) & found_q & tok_q;
    end else if (tap_hit) begin
      ans_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      answer_q    <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
      answer_q    <= ans_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/khtt_checker.sv
// port level checks of the key hold and tap tracker, bound to the top level
`default_nettype none

module khtt_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [khtt_pkg::ACT_W-1:0]  action_i,
  input wire logic [khtt_pkg::CODE_W-1:0] key_code_i,
  input wire logic [khtt_pkg::TIME_W-1:0] now_i,
  input wire logic [khtt_pkg::TIME_W-1:0] hold_time_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic                        answer_o,
  input wire logic                        cfg_valid_i,
  input wire logic                        cfg_ready_o,
  input wire logic [khtt_pkg::TIME_W-1:0] cfg_data_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(answer_o))
    else $error("stalled result changed");

  // input stays busy after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too early");

  // a new result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work");

  // config is always taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind key_hold_and_tap_tracker_top khtt_checker u_khtt_checker (.*);

`default_nettype wire

// File: dv/key_hold_and_tap_tracker_top_tb.sv
// testbench for the key hold and tap tracker: predicted answers checked against the block
module key_hold_and_tap_tracker_top_tb;
  import khtt_pkg::*;

  localparam int unsigned KEY_SLOTS      = 20;
  localparam int unsigned TAP_DEPTH      = 5;
  localparam int unsigned ITEMS_PER_PASS = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = KEY_SLOTS + 8;

  class key_tracker_scoreboard;
    logic [TIME_W-1:0] tap_limit;
    logic [CODE_W-1:0] held_code [KEY_SLOTS];
    bit                held_valid [KEY_SLOTS];
    logic [TIME_W-1:0] held_since [KEY_SLOTS];
    logic [CODE_W-1:0] tap_code [TAP_DEPTH];
    bit                tap_valid [TAP_DEPTH];
    bit                expected_answers [$];
    int errors;
    int checked;
    int ones;
    int taps_pushed;
    int full_drops;

    function new();
      tap_limit = TAP_LIMIT_RST;
      foreach (held_valid[i]) held_valid[i] = 1'b0;
      foreach (tap_valid[i]) tap_valid[i] = 1'b0;
      errors = 0;
      checked = 0;
      ones = 0;
      taps_pushed = 0;
      full_drops = 0;
    endfunction

    function void set_tap_limit(logic [TIME_W-1:0] value);
      tap_limit = value;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    function int find_key(logic [CODE_W-1:0] code);
      int slot;
      slot = -1;
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
        if (held_valid[i] && held_code[i] == code) slot = i;
      end
      return slot;
    endfunction

    function void add_key_event(act_e act, logic [CODE_W-1:0] code,
                                logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] hold);
      bit                ans;
      int                slot;
      logic [TIME_W-1:0] dur;
      ans = 1'b0;
      case (act)
        ACT_PRESS: begin
          if (find_key(code) < 0) begin
            slot = -1;
            for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
              if (!held_valid[i]) slot = i;
            end
            if (slot < 0) begin
              full_drops++;
            end else begin
              held_valid[slot] = 1'b1;
              held_code[slot]  = code;
              held_since[slot] = stamp;
            end
          end
        end
        ACT_RELEASE: begin
          slot = find_key(code);
          if (slot >= 0) begin
            held_valid[slot] = 1'b0;
            dur = stamp - held_since[slot];
            if (dur < tap_limit) begin
              for (int i = TAP_DEPTH - 1; i > 0; i--) begin
                tap_code[i]  = tap_code[i-1];
                tap_valid[i] = tap_valid[i-1];
              end
              tap_code[0]  = code;
              tap_valid[0] = 1'b1;
              taps_pushed++;
            end
          end
        end
        ACT_HELD: begin
          for (int i = 0; i < KEY_SLOTS; i++) begin
            dur = stamp - held_since[i];
            if (held_valid[i] && held_code[i] == code && dur > hold) ans = 1'b1;
          end
        end
        default: begin
          for (int i = 0; i < TAP_DEPTH && !ans; i++) begin
            if (tap_valid[i] && tap_code[i] == code) begin
              tap_valid[i] = 1'b0;
              ans = 1'b1;
            end
          end
        end
      endcase
      expected_answers.push_back(ans);
    endfunction

    function void check_answer(logic got);
      bit exp_answer;
      if (expected_answers.size() == 0) begin
        $error("answer word with nothing expected: actual %0b", got);
        errors++;
      end else begin
        exp_answer = expected_answers.pop_front();
        checked++;
        if (exp_answer) ones++;
        if (got !== exp_answer) begin
          $error("answer mismatch: expected %0b, actual %0b", exp_answer, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ACT_W-1:0]  action_i;
  logic [CODE_W-1:0] key_code_i;
  logic [TIME_W-1:0] now_i;
  logic [TIME_W-1:0] hold_time_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              answer_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [TIME_W-1:0] cfg_data_i;

  key_tracker_scoreboard answers;
  logic [TIME_W-1:0]     tick;
  logic [TIME_W-1:0]     cur_tap_limit;
  logic [CODE_W-1:0]     code_pool [24];
  int                    pool_size;
  int                    items_sent;
  int                    cfg_writes;
  int                    tx_calm;
  int                    rx_calm;
  int                    quiet_cycles;
  bit                    hold_off_req;

  key_hold_and_tap_tracker_top #(
    .KEY_SLOTS(KEY_SLOTS),
    .TAP_DEPTH(TAP_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .key_code_i (key_code_i),
    .now_i      (now_i),
    .hold_time_i(hold_time_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .answer_o   (answer_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 80);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    logic [31:0] r;
    r = $urandom();
    return r[CODE_W-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(0, 99) < 8) return rand_code();
    return code_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  function automatic logic [TIME_W-1:0] pick_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return $urandom();
    return $urandom_range(0, 600);
  endfunction

  function automatic void advance_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) tick = tick + $urandom_range(0, 40);
    else if (r < 95) tick = tick + $urandom_range(0, 400);
    else tick = tick + $urandom();
  endfunction

  function automatic void refill_pool();
    pool_size = $urandom_range(4, 24);
    code_pool[0] = '0;
    code_pool[1] = '1;
    for (int i = 2; i < 24; i++) begin
      if ($urandom_range(0, 1) == 0) code_pool[i] = CODE_W'($urandom_range(1, 40));
      else code_pool[i] = rand_code();
    end
  endfunction

  task automatic send_key_event(act_e act, logic [CODE_W-1:0] code,
                                logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] hold);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    key_code_i  <= code;
    now_i       <= stamp;
    hold_time_i <= hold;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    answers.add_key_event(act, code, stamp, hold);
    items_sent++;
  endtask

  task automatic write_tap_limit(logic [TIME_W-1:0] value);
    in_valid_i <= 1'b0;
    while (answers.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    answers.set_tap_limit(value);
    cur_tap_limit = value;
    cfg_writes++;
  endtask

  task automatic run_single();
    int                r;
    act_e              act;
    logic [TIME_W-1:0] stamp;
    r = $urandom_range(0, 99);
    if (r < 30) act = ACT_PRESS;
    else if (r < 60) act = ACT_RELEASE;
    else if (r < 80) act = ACT_HELD;
    else act = ACT_TAP;
    advance_ticks();
    stamp = ($urandom_range(0, 99) < 3) ? $urandom() : tick;
    send_key_event(act, pick_code(), stamp, pick_hold());
  endtask

  task automatic run_gesture();
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] delay;
    code = pick_code();
    send_key_event(ACT_PRESS, code, tick, $urandom());
    if (cur_tap_limit <= 32'd100000) delay = $urandom_range(0, 2 * cur_tap_limit + 2);
    else delay = $urandom();
    if ($urandom_range(0, 1) == 0) begin
      send_key_event(ACT_HELD, code, tick + delay / 2,
                     delay / 2 + $urandom_range(0, 4) - 2);
    end
    tick = tick + delay;
    send_key_event(ACT_RELEASE, code, tick, $urandom());
    if ($urandom_range(0, 99) < 70) begin
      send_key_event(ACT_TAP, ($urandom_range(0, 99) < 70) ? code : pick_code(),
                     tick, $urandom());
    end
    advance_ticks();
  endtask

  task automatic run_sweep();
    logic [CODE_W-1:0] base;
    logic [CODE_W-1:0] code;
    base = rand_code();
    for (int i = 0; i < KEY_SLOTS + 2; i++) begin
      code = base + CODE_W'(i);
      tick = tick + $urandom_range(0, 5);
      send_key_event(ACT_PRESS, code, tick, $urandom());
    end
    for (int i = 0; i < KEY_SLOTS + 2; i++) begin
      code = base + CODE_W'(i);
      tick = tick + $urandom_range(0, 8);
      send_key_event(ACT_HELD, code, tick, $urandom_range(0, 100));
      send_key_event(ACT_RELEASE, code, tick, $urandom());
    end
    for (int i = 0; i < TAP_DEPTH + 2; i++) begin
      code = base + CODE_W'($urandom_range(0, KEY_SLOTS + 1));
      send_key_event(ACT_TAP, code, tick, $urandom());
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_gap(rx_calm);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      answers.check_answer(answer_o);
    end
  end

  initial begin : key_stimulus
    logic [TIME_W-1:0] settings [6];
    int                pass_start;
    int                r;
    answers       = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_PRESS;
    key_code_i    = '0;
    now_i         = '0;
    hold_time_i   = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    quiet_cycles  = 0;
    hold_off_req  = 1'b0;
    items_sent    = 0;
    cfg_writes    = 0;
    tx_calm       = 0;
    rx_calm       = 0;
    tick          = '0;
    cur_tap_limit = TAP_LIMIT_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the tap limit in force here
    send_key_event(ACT_TAP, 31'd5, 32'd0, 32'd0);
    send_key_event(ACT_HELD, 31'd0, 32'd0, 32'd0);
    send_key_event(ACT_PRESS, 31'd0, 32'd100, '1);
    send_key_event(ACT_PRESS, 31'd0, 32'd150, '1);
    send_key_event(ACT_HELD, 31'd0, 32'd300, 32'd199);
    send_key_event(ACT_HELD, 31'd0, 32'd300, 32'd200);
    send_key_event(ACT_PRESS, '1, 32'hFFFF_FFF0, '0);
    send_key_event(ACT_HELD, '1, 32'h10, 32'h1F);
    send_key_event(ACT_HELD, '1, 32'h10, '1);
    send_key_event(ACT_RELEASE, '1, 32'h20, '0);
    send_key_event(ACT_RELEASE, 31'd0, 32'd250, '0);
    send_key_event(ACT_RELEASE, 31'd0, 32'd260, '0);
    send_key_event(ACT_TAP, '1, 32'd300, '0);
    send_key_event(ACT_TAP, '1, 32'd300, '0);
    send_key_event(ACT_PRESS, 31'd9, 32'd1000, '0);
    send_key_event(ACT_RELEASE, 31'd9, 32'd1200, '0);
    send_key_event(ACT_TAP, 31'd9, 32'd1200, '0);
    send_key_event(ACT_PRESS, 31'd3, 32'd2000, '0);
    send_key_event(ACT_RELEASE, 31'd3, 32'd2001, '0);
    send_key_event(ACT_PRESS, 31'd3, 32'd2002, '0);
    send_key_event(ACT_RELEASE, 31'd3, 32'd2002, '0);
    send_key_event(ACT_TAP, 31'd3, 32'd2003, '0);
    send_key_event(ACT_TAP, 31'd3, 32'd2003, '0);
    send_key_event(ACT_TAP, 31'd3, 32'd2003, '0);
    send_key_event(ACT_TAP, 31'd0, 32'd2003, '0);

    settings[0] = TAP_LIMIT_RST;
    settings[1] = '0;
    settings[2] = '1;
    settings[3] = 32'd1;
    settings[4] = $urandom_range(50, 600);
    settings[5] = $urandom();
    tick = 32'd5000;
    foreach (settings[p]) begin
      write_tap_limit(settings[p]);
      refill_pool();
      if (p == 0) hold_off_req = 1'b1;
      pass_start = items_sent;
      while (items_sent - pass_start < ITEMS_PER_PASS) begin
        r = $urandom_range(0, 99);
        if (r < 3) run_sweep();
        else if (r < 40) run_gesture();
        else run_single();
      end
    end

    in_valid_i <= 1'b0;
    while (answers.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (answers.pending() != 0) begin
      $error("answer words still expected at the end: %0d", answers.pending());
      answers.errors++;
    end
    $display("%0d key events over %0d tap limit settings, %0d answers checked (%0d set)",
             items_sent, cfg_writes, answers.checked, answers.ones);
    $display("%0d taps recorded, %0d presses dropped on a full slot table",
             answers.taps_pushed, answers.full_drops);
    if (answers.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
